FILE: hdl/bts_pkg.sv
// Shared types, constants and decode tables for the bilinear texture sampler.
// Used by every module under hdl/; depends on nothing.
package bts_pkg;

  localparam int unsigned DEF_MAX_WIDTH     = 256;
  localparam int unsigned DEF_MAX_HEIGHT    = 256;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  localparam int unsigned LUT_W = 25;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_CHANNEL_MODE = 2'd2,
    REG_TEX_PRESENT  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // Per-item control that rides with the bank read
  typedef struct packed {
    logic valid;
    logic sample;
    logic x0p;
    logic x1p;
    logic y0p;
    logic y1p;
  } smp_ctl_t;

  typedef logic [LUT_W-1:0] lut_t [256];

  // sRGB byte to linear, rounded half up to f fraction bits
  function automatic lut_t srgb_table(input int f);
    lut_t   t;
    real    x;
    longint n;
    for (int b = 0; b < 256; b++) begin
      if (b <= 10) begin
        n    = (longint'(b) * 100 * (longint'(1) << f) + 164730) / 329460;
        t[b] = LUT_W'(n);
      end else begin
        x    = ((real'(b) / 255.0 + 0.055) / 1.055) ** 2.4 * (2.0 ** f);
        t[b] = LUT_W'($rtoi(x + 0.5));
      end
    end
    return t;
  endfunction

  // Grey byte / 255, rounded to nearest
  function automatic lut_t grey_table(input int f);
    lut_t   t;
    longint n;
    for (int b = 0; b < 256; b++) begin
      n    = (longint'(b) * (longint'(1) << f) + 127) / 255;
      t[b] = LUT_W'(n);
    end
    return t;
  endfunction

  // Clamp a signed 20-bit coordinate to [0, 2^f]
  function automatic logic [31:0] clamp_coord(input logic [19:0] c, input int f);
    logic [31:0] one;
    one = 32'd1 << f;
    if (c[19]) begin
      return 32'd0;
    end else if (32'(c[18:0]) > one) begin
      return one;
    end
    return 32'(c[18:0]);
  endfunction

endpackage

FILE: hdl/bilinear_texture_sampler_core.sv
// Bilinear texture sampler top level: configuration registers, stall control,
// and the address, memory and filter pipeline. Depends on bts_pkg and bts_* modules.
//
// Usage:
//   Input stream (s_axis_*): tuser selects the operation, write texel or sample.
//   A write stores three raw bytes at (column, row) and yields no item; a sample
//   yields one item on m_axis_* with filtered linear red, green and blue, Q1.16.
//   Configuration (cfg_*) sets size, channel mode and texture presence; write it
//   only while no item is in flight.
// Throughput:
//   One item is taken every cycle while the output is not stalled; the four
//   neighboring texels come from four parity banks, one read port each, in a
//   single cycle.
// Reset:
//   Pipeline valid bits clear; width and height 1, sRGB mode, no texture.
//   Texel memory content is undefined until written.
// Stall:
//   When the output holds an item that is not taken, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.
module bilinear_texture_sampler_core import bts_pkg::*; #(
  parameter int unsigned MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // texel_column, texel_row, red_byte, green_byte, blue_byte, coord_u, coord_v
  input  logic [79:0] s_axis_tdata,
  // operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red_linear, green_linear, blue_linear, zero pad
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int unsigned XW  = $clog2(MAX_WIDTH);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT);
  localparam int unsigned CBW = (XW > 1) ? XW - 1 : 1;
  localparam int unsigned RBW = (YW > 1) ? YW - 1 : 1;
  localparam int unsigned AW  = CBW + RBW;

  logic [XW-1:0] wm1_q, wm1_d;
  logic [YW-1:0] hm1_q, hm1_d;
  logic          mode_q, present_q;

  // Hold effective size minus one: zero acts as one, oversize as the maximum
  always_comb begin
    if (cfg_data_i == 9'd0) begin
      wm1_d = '0;
    end else if (32'(cfg_data_i) > MAX_WIDTH) begin
      wm1_d = XW'(MAX_WIDTH - 1);
    end else begin
      wm1_d = XW'(cfg_data_i - 9'd1);
    end
    if (cfg_data_i == 9'd0) begin
      hm1_d = '0;
    end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
      hm1_d = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1_d = YW'(cfg_data_i - 9'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q     <= '0;
      hm1_q     <= '0;
      mode_q    <= 1'b1;
      present_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  wm1_q     <= wm1_d;
        REG_IMAGE_HEIGHT: hm1_q     <= hm1_d;
        REG_CHANNEL_MODE: mode_q    <= cfg_data_i[0];
        REG_TEX_PRESENT:  present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  smp_ctl_t                  ctl;
  logic [FRACTION_BITS-1:0]  tx, ty;
  logic [3:0][AW-1:0]        rd_addr;
  logic                      wr_en;
  logic [1:0]                wr_bank;
  logic [AW-1:0]             wr_addr;
  logic [23:0]               wr_data;
  logic [3:0][23:0]          rd_data;
  logic [16:0]               red, green, blue;

  bts_addr #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_addr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (s_axis_tvalid),
    .op_i       (s_axis_tuser),
    .col_i      (s_axis_tdata[7:0]),
    .row_i      (s_axis_tdata[15:8]),
    .rgb_i      ({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
    .u_i        (s_axis_tdata[59:40]),
    .v_i        (s_axis_tdata[79:60]),
    .wm1_i      (wm1_q),
    .hm1_i      (hm1_q),
    .ctl_o      (ctl),
    .tx_o       (tx),
    .ty_o       (ty),
    .rd_addr_o  (rd_addr),
    .wr_en_o    (wr_en),
    .wr_bank_o  (wr_bank),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  bts_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .en_i      (en),
    .rd_addr_i (rd_addr),
    .wr_en_i   (wr_en),
    .wr_bank_i (wr_bank),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  bts_filter #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .ctl_i       (ctl),
    .tx_i        (tx),
    .ty_i        (ty),
    .rd_data_i   (rd_data),
    .mode_i      (mode_q),
    .present_i   (present_q),
    .out_valid_o (m_axis_tvalid),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  assign m_axis_tdata = {5'd0, blue, green, red};

  localparam logic [16:0] ONE_OUT = 17'(1) << FRACTION_BITS;

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (red <= ONE_OUT && green <= ONE_OUT && blue <= ONE_OUT))
    else $error("filtered channel above 1.0");

  a_cyan_without_texture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !present_q) |-> (red == 17'd0 && green == ONE_OUT))
    else $error("no-texture result is not cyan");

endmodule

FILE: hdl/bts_addr.sv
// Coordinate pipeline: clamp, scale to texel space, neighbor and bank addresses.
// Depends on bts_pkg.
module bts_addr import bts_pkg::*; #(
  parameter int unsigned MAX_WIDTH     = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT    = DEF_MAX_HEIGHT,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS,
  localparam int unsigned XW  = $clog2(MAX_WIDTH),
  localparam int unsigned YW  = $clog2(MAX_HEIGHT),
  localparam int unsigned CBW = (XW > 1) ? XW - 1 : 1,
  localparam int unsigned RBW = (YW > 1) ? YW - 1 : 1,
  localparam int unsigned AW  = CBW + RBW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  input  logic                         op_i,
  input  logic [7:0]                   col_i,
  input  logic [7:0]                   row_i,
  input  logic [23:0]                  rgb_i,
  input  logic [19:0]                  u_i,
  input  logic [19:0]                  v_i,
  input  logic [XW-1:0]                wm1_i,
  input  logic [YW-1:0]                hm1_i,
  output smp_ctl_t                     ctl_o,
  output logic [FRACTION_BITS-1:0]     tx_o,
  output logic [FRACTION_BITS-1:0]     ty_o,
  output logic [3:0][AW-1:0]           rd_addr_o,
  output logic                         wr_en_o,
  output logic [1:0]                   wr_bank_o,
  output logic [AW-1:0]                wr_addr_o,
  output logic [23:0]                  wr_data_o
);

  localparam int unsigned F = FRACTION_BITS;
  localparam logic [F:0] ONE = (F+1)'(1) << F;

  // Stage 1: clamped coordinates, v flipped
  logic              v1_q, op1_q;
  logic [F:0]        u1_q, vf1_q;
  logic [7:0]        col1_q, row1_q;
  logic [23:0]       rgb1_q;
  logic [F:0]        uc, vc;

  assign uc = (F+1)'(clamp_coord(u_i, F));
  assign vc = (F+1)'(clamp_coord(v_i, F));

  // Stage 2: scaled coordinates
  logic              v2_q, op2_q;
  logic [F+XW:0]     xf2_q;
  logic [F+YW:0]     yf2_q;
  logic [7:0]        col2_q, row2_q;
  logic [23:0]       rgb2_q;

  // Stage 3: neighbor indices and fractions
  logic              v3_q, op3_q;
  logic [XW-1:0]     x0_3_q, x1_3_q;
  logic [YW-1:0]     y0_3_q, y1_3_q;
  logic [F-1:0]      tx3_q, ty3_q;
  logic [7:0]        col3_q, row3_q;
  logic [23:0]       rgb3_q;

  logic [XW-1:0]     x0_d, x1_d;
  logic [YW-1:0]     y0_d, y1_d;

  assign x0_d = xf2_q[F+XW-1:F];
  assign y0_d = yf2_q[F+YW-1:F];
  assign x1_d = (x0_d == wm1_i) ? x0_d : x0_d + XW'(1);
  assign y1_d = (y0_d == hm1_i) ? y0_d : y0_d + YW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q  <= op_i;
      u1_q   <= uc;
      vf1_q  <= ONE - vc;
      col1_q <= col_i;
      row1_q <= row_i;
      rgb1_q <= rgb_i;

      op2_q  <= op1_q;
      xf2_q  <= (F+XW+1)'(u1_q) * (F+XW+1)'(wm1_i);
      yf2_q  <= (F+YW+1)'(vf1_q) * (F+YW+1)'(hm1_i);
      col2_q <= col1_q;
      row2_q <= row1_q;
      rgb2_q <= rgb1_q;

      op3_q  <= op2_q;
      x0_3_q <= x0_d;
      x1_3_q <= x1_d;
      y0_3_q <= y0_d;
      y1_3_q <= y1_d;
      tx3_q  <= xf2_q[F-1:0];
      ty3_q  <= yf2_q[F-1:0];
      col3_q <= col2_q;
      row3_q <= row2_q;
      rgb3_q <= rgb2_q;
    end
  end

  // Bank b holds texels with column parity b[0] and row parity b[1]
  always_comb begin
    logic [XW-1:0] xs;
    logic [YW-1:0] ys;
    for (int b = 0; b < 4; b++) begin
      xs = (x0_3_q[0] == b[0]) ? x0_3_q : x1_3_q;
      ys = (y0_3_q[0] == b[1]) ? y0_3_q : y1_3_q;
      rd_addr_o[b] = {RBW'(ys >> 1), CBW'(xs >> 1)};
    end
  end

  logic [XW-1:0] wcol;
  logic [YW-1:0] wrow;
  logic          w_in_range;

  assign wcol       = XW'(col3_q);
  assign wrow       = YW'(row3_q);
  assign w_in_range = (32'(col3_q) < MAX_WIDTH) && (32'(row3_q) < MAX_HEIGHT);

  assign wr_en_o   = v3_q && (op3_q == OP_WRITE) && w_in_range;
  assign wr_bank_o = {row3_q[0], col3_q[0]};
  assign wr_addr_o = {RBW'(wrow >> 1), CBW'(wcol >> 1)};
  assign wr_data_o = rgb3_q;

  assign ctl_o.valid  = v3_q;
  assign ctl_o.sample = (op3_q == OP_SAMPLE);
  assign ctl_o.x0p    = x0_3_q[0];
  assign ctl_o.x1p    = x1_3_q[0];
  assign ctl_o.y0p    = y0_3_q[0];
  assign ctl_o.y1p    = y1_3_q[0];
  assign tx_o         = tx3_q;
  assign ty_o         = ty3_q;

endmodule

FILE: hdl/bts_mem.sv
// Texel store split into four parity banks, one read port each, registered reads.
// Depends on bts_pkg.
module bts_mem import bts_pkg::*; #(
  parameter int unsigned AW = 14
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [3:0][AW-1:0]  rd_addr_i,
  input  logic                wr_en_i,
  input  logic [1:0]          wr_bank_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [23:0]         wr_data_i,
  output logic [3:0][23:0]    rd_data_o
);

  localparam int unsigned DEPTH = 1 << AW;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [23:0] mem [DEPTH];
    logic [23:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (wr_en_i && (wr_bank_i == 2'(b))) begin
          mem[wr_addr_i] <= wr_data_i;
        end
        rd_q <= mem[rd_addr_i[b]];
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

FILE: hdl/bts_filter.sv
// Texel selection, channel decode and two-pass bilinear blend with output register.
// Depends on bts_pkg.
module bts_filter import bts_pkg::*; #(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  smp_ctl_t                  ctl_i,
  input  logic [FRACTION_BITS-1:0]  tx_i,
  input  logic [FRACTION_BITS-1:0]  ty_i,
  input  logic [3:0][23:0]          rd_data_i,
  input  logic                      mode_i,
  input  logic                      present_i,
  output logic                      out_valid_o,
  output logic [16:0]               red_o,
  output logic [16:0]               green_o,
  output logic [16:0]               blue_o
);

  localparam int unsigned F = FRACTION_BITS;
  localparam logic [F:0] ONE  = (F+1)'(1) << F;
  localparam lut_t SRGB_TAB   = srgb_table(F);
  localparam lut_t GREY_TAB   = grey_table(F);

  function automatic logic [F:0] blend(input logic [F:0] a, input logic [F:0] b,
                                       input logic [F-1:0] f);
    logic [2*F+1:0] s;
    s = (2*F+2)'(a) * (2*F+2)'(ONE - (F+1)'(f)) + (2*F+2)'(b) * (2*F+2)'(f)
        + ((2*F+2)'(1) << (F - 1));
    return s[2*F:F];
  endfunction

  // Stage 4: control aligned with bank read data
  smp_ctl_t      ctl4_q;
  logic [F-1:0]  tx4_q, ty4_q;

  // Stage 5: decoded corners, index 0..3 = c00, c10, c01, c11
  logic          v5_q;
  logic [F-1:0]  tx5_q, ty5_q;
  logic [F:0]    c5_q [4][3];

  // Stage 6: row blends
  logic          v6_q;
  logic [F-1:0]  ty6_q;
  logic [F:0]    top6_q [3];
  logic [F:0]    bot6_q [3];

  // Stage 7: output
  logic          v7_q;
  logic [16:0]   out7_q [3];

  logic [23:0]   tex [4];
  logic [F:0]    dec [4][3];

  always_comb begin
    tex[0] = rd_data_i[{ctl4_q.y0p, ctl4_q.x0p}];
    tex[1] = rd_data_i[{ctl4_q.y0p, ctl4_q.x1p}];
    tex[2] = rd_data_i[{ctl4_q.y1p, ctl4_q.x0p}];
    tex[3] = rd_data_i[{ctl4_q.y1p, ctl4_q.x1p}];
    for (int k = 0; k < 4; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        dec[k][ch] = mode_i ? (F+1)'(SRGB_TAB[tex[k][23-8*ch -: 8]])
                            : (F+1)'(GREY_TAB[tex[k][23:16]]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      v7_q   <= 1'b0;
    end else if (en_i) begin
      ctl4_q <= ctl_i;
      v5_q   <= ctl4_q.valid && ctl4_q.sample;
      v6_q   <= v5_q;
      v7_q   <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tx4_q <= tx_i;
      ty4_q <= ty_i;
      tx5_q <= tx4_q;
      ty5_q <= ty4_q;
      c5_q  <= dec;
      ty6_q <= ty5_q;
      for (int ch = 0; ch < 3; ch++) begin
        top6_q[ch] <= blend(c5_q[0][ch], c5_q[1][ch], tx5_q);
        bot6_q[ch] <= blend(c5_q[2][ch], c5_q[3][ch], tx5_q);
        out7_q[ch] <= 17'(blend(top6_q[ch], bot6_q[ch], ty6_q));
      end
    end
  end

  // Without a texture, answer cyan
  assign out_valid_o = v7_q;
  assign red_o       = present_i ? out7_q[0] : 17'd0;
  assign green_o     = present_i ? out7_q[1] : 17'(ONE);
  assign blue_o      = present_i ? out7_q[2] : 17'(ONE);

endmodule
